FILE: src/hssc_pkg.sv
// Shared types, codes, tables and constants of the six-step commutator.
package hssc_pkg;

  // Depth of the period history ring
  localparam int HISTORY = 540;
  localparam int IDX_W   = (HISTORY > 1) ? $clog2(HISTORY) : 1;
  localparam int SUM_W   = $clog2(HISTORY) + 32;

  // Reciprocal of the history depth, scaled by 2^SUM_W
  localparam int RECIP_W = SUM_W - $clog2(HISTORY) + 1;
  localparam longint unsigned RECIP_FULL = (64'd1 << SUM_W) / HISTORY;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
  localparam int HIST_W  = $clog2(HISTORY + 1);

  localparam int DUTY_W  = 20;
  localparam logic [DUTY_W-1:0] DUTY_FULL = 20'd1000000;

  // Output queue
  localparam int OFIFO_DEPTH = 8;
  localparam int PTR_W       = $clog2(OFIFO_DEPTH);

  // Commands
  localparam logic [2:0] CMD_HALL  = 3'd0;
  localparam logic [2:0] CMD_TICK  = 3'd1;
  localparam logic [2:0] CMD_START = 3'd2;
  localparam logic [2:0] CMD_STOP  = 3'd3;
  localparam logic [2:0] CMD_RAISE = 3'd4;
  localparam logic [2:0] CMD_LOWER = 3'd5;
  localparam logic [2:0] CMD_QUERY = 3'd6;

  // Run modes
  localparam logic [1:0] MODE_STILL  = 2'd0;
  localparam logic [1:0] MODE_FORCED = 2'd1;
  localparam logic [1:0] MODE_CHECK  = 2'd2;
  localparam logic [1:0] MODE_RUN    = 2'd3;

  // Hall pins
  localparam logic [1:0] PIN_H1 = 2'd0;
  localparam logic [1:0] PIN_H2 = 2'd1;
  localparam logic [1:0] PIN_H3 = 2'd2;

  // Sectors
  localparam logic [2:0] SEC_NONE = 3'd0;
  localparam logic [2:0] SEC_1    = 3'd1;
  localparam logic [2:0] SEC_2    = 3'd2;
  localparam logic [2:0] SEC_3    = 3'd3;
  localparam logic [2:0] SEC_4    = 3'd4;
  localparam logic [2:0] SEC_5    = 3'd5;
  localparam logic [2:0] SEC_6    = 3'd6;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCED_DUTY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_DUTY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_STEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL_TICKS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCED_TURNS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_TICKS  = 3'd5;

  typedef struct packed {
    logic [2:0]        sector;
    logic [2:0]        enable_mask;
    logic [1:0]        pwm_phase;
    logic [DUTY_W-1:0] pwm_duty;
    logic              sector_one;
    logic [1:0]        run_mode;
    logic              avg_valid;
  } res_t;

  typedef struct packed {
    res_t        res;
    logic [31:0] avg;
  } out_t;

  function automatic logic [1:0] phase_of(input logic [2:0] s);
    logic [1:0] p;
    unique case (s)
      SEC_1, SEC_6: p = 2'd1;
      SEC_2, SEC_3: p = 2'd2;
      SEC_4, SEC_5: p = 2'd3;
      default:      p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic [2:0] mask_of(input logic [2:0] s);
    logic [2:0] m;
    unique case (s)
      SEC_1, SEC_4: m = 3'd5;
      SEC_2, SEC_5: m = 3'd6;
      SEC_3, SEC_6: m = 3'd3;
      default:      m = 3'd0;
    endcase
    return m;
  endfunction

endpackage

FILE: src/hssc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module hssc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: src/hssc_core.sv
// Commutation state update, period ring read-modify-write and config registers.
module hssc_core
  import hssc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_fire,
  input  logic [2:0]            command,
  input  logic [1:0]            hall_pin,
  input  logic                  hall_level,
  input  logic [31:0]           timestamp,
  output logic                  res_valid,
  output res_t                  res,
  output logic [SUM_W-1:0]      res_sum
);

  logic [DUTY_W-1:0] forced_duty, start_duty, duty_step;
  logic [15:0]       dwell_ticks, check_ticks;
  logic [7:0]        forced_turns;

  logic [1:0]        mode, mode_next;
  logic [DUTY_W-1:0] duty, duty_next;
  logic [DUTY_W-1:0] applied_duty, applied_duty_next;
  logic [2:0]        sector, sector_next;
  logic [2:0]        enables, enables_next;
  logic [15:0]       dwell_count, dwell_count_next;
  logic [7:0]        turn_count, turn_count_next;
  logic [15:0]       check_count, check_count_next;
  logic              edge_seen, edge_seen_next;
  logic [31:0]       last_stamp, last_stamp_next;
  logic [IDX_W-1:0]  ring_idx, ring_idx_next;
  logic              ring_filled, ring_filled_next;
  logic [SUM_W-1:0]  period_sum, period_sum_next;

  logic              ring_we;
  logic [31:0]       diff;
  logic [31:0]       rd_data;
  logic              fwd_hit;
  logic [31:0]       fwd_data;
  logic [31:0]       ring_old;

  logic              apply;
  logic [2:0]        apply_sec;
  logic [16:0]       dwell_inc;
  logic [8:0]        turn_inc;
  logic [16:0]       check_inc;
  logic [15:0]       dwell_eff, check_eff;
  logic [7:0]        turns_eff;
  logic [DUTY_W:0]   raised;

  function automatic logic [DUTY_W-1:0] sat_duty(input logic [DUTY_W:0] v);
    return (v > {1'b0, DUTY_FULL}) ? DUTY_FULL : v[DUTY_W-1:0];
  endfunction

  hssc_ram #(.WIDTH(32), .DEPTH(HISTORY)) u_ring (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (ring_idx),
    .wr_data (diff),
    .rd_addr (ring_idx_next),
    .rd_data (rd_data)
  );

  // Entry at the write position holds data only after the first wrap
  assign ring_old = !ring_filled ? 32'd0 : (fwd_hit ? fwd_data : rd_data);
  assign diff     = timestamp - last_stamp;

  assign dwell_eff = (dwell_ticks == 16'd0) ? 16'd1 : dwell_ticks;
  assign check_eff = (check_ticks == 16'd0) ? 16'd1 : check_ticks;
  assign turns_eff = (forced_turns == 8'd0) ? 8'd1 : forced_turns;
  assign dwell_inc = {1'b0, dwell_count} + 17'd1;
  assign check_inc = {1'b0, check_count} + 17'd1;
  assign turn_inc  = {1'b0, turn_count} + 9'd1;
  assign raised    = {1'b0, duty} + {1'b0, duty_step};

  always_comb begin
    mode_next         = mode;
    duty_next         = duty;
    applied_duty_next = applied_duty;
    sector_next       = sector;
    enables_next      = enables;
    dwell_count_next  = dwell_count;
    turn_count_next   = turn_count;
    check_count_next  = check_count;
    edge_seen_next    = edge_seen;
    last_stamp_next   = last_stamp;
    ring_idx_next     = ring_idx;
    ring_filled_next  = ring_filled;
    period_sum_next   = period_sum;
    ring_we           = 1'b0;
    apply             = 1'b0;
    apply_sec         = SEC_NONE;

    if (in_fire) begin
      unique case (command)
        CMD_HALL: begin
          if ((mode == MODE_CHECK || mode == MODE_RUN) && hall_pin != 2'd3) begin
            edge_seen_next = 1'b1;
            apply          = 1'b1;
            priority if (hall_pin == PIN_H3 && hall_level) begin
              apply_sec       = SEC_1;
              ring_we         = 1'b1;
              last_stamp_next = timestamp;
              period_sum_next = period_sum - SUM_W'(ring_old) + SUM_W'(diff);
              ring_idx_next   = (ring_idx == IDX_W'(HISTORY - 1)) ? '0 : ring_idx + 1'b1;
              ring_filled_next = ring_filled | (ring_idx == IDX_W'(HISTORY - 1));
            end else if (hall_pin == PIN_H2 && !hall_level) begin
              apply_sec = SEC_2;
            end else if (hall_pin == PIN_H1 && hall_level) begin
              apply_sec = SEC_3;
            end else if (hall_pin == PIN_H3) begin
              apply_sec = SEC_4;
            end else if (hall_pin == PIN_H2) begin
              apply_sec = SEC_5;
            end else begin
              apply_sec = SEC_6;
            end
          end
        end
        CMD_TICK: begin
          if (mode == MODE_FORCED) begin
            if (dwell_inc < {1'b0, dwell_eff}) begin
              dwell_count_next = dwell_inc[15:0];
            end else begin
              dwell_count_next = '0;
              if (sector >= SEC_6 || sector == SEC_NONE) begin
                turn_count_next = turn_inc[7:0];
                if (turn_inc >= {1'b0, turns_eff}) begin
                  mode_next        = MODE_CHECK;
                  duty_next        = sat_duty({1'b0, start_duty});
                  edge_seen_next   = 1'b0;
                  check_count_next = '0;
                end else begin
                  apply     = 1'b1;
                  apply_sec = SEC_1;
                end
              end else begin
                apply     = 1'b1;
                apply_sec = sector + 3'd1;
              end
            end
          end else if (mode == MODE_CHECK) begin
            if (check_inc < {1'b0, check_eff}) begin
              check_count_next = check_inc[15:0];
            end else begin
              check_count_next = '0;
              if (edge_seen) begin
                mode_next = MODE_RUN;
              end else begin
                enables_next = 3'd0;
                mode_next    = MODE_STILL;
              end
            end
          end
        end
        CMD_START: begin
          if (mode == MODE_STILL) begin
            mode_next        = MODE_FORCED;
            duty_next        = sat_duty({1'b0, forced_duty});
            dwell_count_next = '0;
            turn_count_next  = '0;
            apply            = 1'b1;
            apply_sec        = SEC_1;
          end
        end
        CMD_STOP: begin
          if (mode != MODE_STILL) begin
            enables_next = 3'd0;
            mode_next    = MODE_STILL;
          end
        end
        CMD_RAISE: duty_next = sat_duty(raised);
        CMD_LOWER: duty_next = (duty > duty_step) ? duty - duty_step : '0;
        default: ;
      endcase
    end

    if (apply) begin
      sector_next       = apply_sec;
      enables_next      = mask_of(apply_sec);
      applied_duty_next = duty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      forced_duty  <= 20'd400000;
      start_duty   <= 20'd400000;
      duty_step    <= 20'd20000;
      dwell_ticks  <= 16'd100;
      forced_turns <= 8'd56;
      check_ticks  <= 16'd50000;
      mode         <= MODE_STILL;
      duty         <= '0;
      applied_duty <= '0;
      sector       <= SEC_NONE;
      enables      <= '0;
      dwell_count  <= '0;
      turn_count   <= '0;
      check_count  <= '0;
      edge_seen    <= 1'b0;
      last_stamp   <= '0;
      ring_idx     <= '0;
      ring_filled  <= 1'b0;
      period_sum   <= '0;
      fwd_hit      <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FORCED_DUTY:  forced_duty  <= cfg_data;
          CFG_START_DUTY:   start_duty   <= cfg_data;
          CFG_DUTY_STEP:    duty_step    <= cfg_data;
          CFG_DWELL_TICKS:  dwell_ticks  <= cfg_data[15:0];
          CFG_FORCED_TURNS: forced_turns <= cfg_data[7:0];
          CFG_CHECK_TICKS:  check_ticks  <= cfg_data[15:0];
          default: ;
        endcase
      end
      mode         <= mode_next;
      duty         <= duty_next;
      applied_duty <= applied_duty_next;
      sector       <= sector_next;
      enables      <= enables_next;
      dwell_count  <= dwell_count_next;
      turn_count   <= turn_count_next;
      check_count  <= check_count_next;
      edge_seen    <= edge_seen_next;
      last_stamp   <= last_stamp_next;
      ring_idx     <= ring_idx_next;
      ring_filled  <= ring_filled_next;
      period_sum   <= period_sum_next;
      // Read and write hit the same entry only with a one-deep ring
      fwd_hit      <= ring_we && (ring_idx == ring_idx_next);
      res_valid    <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    fwd_data            <= diff;
    res.sector          <= sector_next;
    res.enable_mask     <= enables_next;
    res.pwm_phase       <= phase_of(sector_next);
    res.pwm_duty        <= applied_duty_next;
    res.sector_one      <= (sector_next == SEC_1);
    res.run_mode        <= mode_next;
    res.avg_valid       <= (command == CMD_QUERY);
    res_sum             <= period_sum_next;
  end

endmodule

FILE: src/hssc_avg.sv
// Pipelined division of the period sum by the history depth.
module hssc_avg
  import hssc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  res_t             in_res,
  input  logic [SUM_W-1:0] in_sum,
  output logic             out_valid,
  output out_t             out_item
);

  localparam int LO_W   = SUM_W / 2;
  localparam int HI_W   = SUM_W - LO_W;
  localparam int ML_W   = RECIP_W / 2;
  localparam int MH_W   = RECIP_W - ML_W;
  localparam int PROD_W = SUM_W + RECIP_W;

  localparam logic [ML_W-1:0] M_LO = RECIP[ML_W-1:0];
  localparam logic [MH_W-1:0] M_HI = RECIP[RECIP_W-1:ML_W];

  logic [3:0]                v;
  res_t                      r1, r2, r3;
  logic [SUM_W-1:0]          s1, s2, s3;
  logic [LO_W+ML_W-1:0]      pp_ll;
  logic [LO_W+MH_W-1:0]      pp_lh;
  logic [HI_W+ML_W-1:0]      pp_hl;
  logic [HI_W+MH_W-1:0]      pp_hh;
  logic [PROD_W-1:0]         total;
  logic [31:0]               q_est2, q_est3;
  logic [31+HIST_W:0]        back;
  logic [SUM_W-1:0]          rem;

  assign total = PROD_W'(pp_ll)
               + (PROD_W'(pp_lh) << ML_W)
               + (PROD_W'(pp_hl) << LO_W)
               + (PROD_W'(pp_hh) << (LO_W + ML_W));

  assign rem = s3 - back[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    // Partial products of sum times reciprocal
    pp_ll <= in_sum[LO_W-1:0] * M_LO;
    pp_lh <= in_sum[LO_W-1:0] * M_HI;
    pp_hl <= in_sum[SUM_W-1:LO_W] * M_LO;
    pp_hh <= in_sum[SUM_W-1:LO_W] * M_HI;
    r1    <= in_res;
    s1    <= in_sum;
    // Estimate is the quotient or one below it
    q_est2 <= total[SUM_W +: 32];
    r2     <= r1;
    s2     <= s1;
    back   <= q_est2 * HIST_W'(HISTORY);
    q_est3 <= q_est2;
    r3     <= r2;
    s3     <= s2;
    out_item.res <= r3;
    out_item.avg <= !r3.avg_valid ? 32'd0 :
                    (rem >= SUM_W'(HISTORY)) ? q_est3 + 32'd1 : q_est3;
  end

  assign out_valid = v[3];

endmodule

FILE: src/hssc_ofifo.sv
// Output queue holding finished results until the consumer takes them.
module hssc_ofifo
  import hssc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  out_t push_item,
  input  logic pop,
  output logic not_empty,
  output out_t head
);

  out_t             mem [OFIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;

  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + PTR_W'(push) - PTR_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: src/hall_six_step_commutator_unit.sv
// Top level of the Hall-sensor six-step commutator.
// Takes one request per cycle while in_stall is low and returns one result per request, in
// order: the state update, which reads the period ring entry prefetched the cycle before
// and writes it back, then the multiply-by-reciprocal divider that forms the average
// period, then the output queue. in_stall rises when eight requests are in flight.
// Ring entries read as zero until the ring has wrapped once, so no clearing pass
// follows reset. The configuration port is always ready.
module hall_six_step_commutator_unit
  import hssc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            command,
  input  logic [1:0]            hall_pin,
  input  logic                  hall_level,
  input  logic [31:0]           timestamp,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            sector,
  output logic [2:0]            enable_mask,
  output logic [1:0]            pwm_phase,
  output logic [DUTY_W-1:0]     pwm_duty,
  output logic                  sector_one,
  output logic [1:0]            run_mode,
  output logic [31:0]           avg_period,
  output logic                  avg_valid
);

  logic             in_fire, out_fire;
  logic [PTR_W:0]   credit;
  logic             res_valid;
  res_t             res;
  logic [SUM_W-1:0] res_sum;
  logic             avg_done;
  out_t             avg_item;
  out_t             head;

  assign cfg_ready = 1'b1;
  assign in_stall  = (credit == (PTR_W + 1)'(OFIFO_DEPTH));
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid && !out_stall;

  // Count requests accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      credit <= credit + PTR_W'(in_fire) - PTR_W'(out_fire);
    end
  end

  hssc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_fire    (in_fire),
    .command    (command),
    .hall_pin   (hall_pin),
    .hall_level (hall_level),
    .timestamp  (timestamp),
    .res_valid  (res_valid),
    .res        (res),
    .res_sum    (res_sum)
  );

  hssc_avg u_avg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_res    (res),
    .in_sum    (res_sum),
    .out_valid (avg_done),
    .out_item  (avg_item)
  );

  hssc_ofifo u_ofifo (
    .clk       (clk),
    .rst       (rst),
    .push      (avg_done),
    .push_item (avg_item),
    .pop       (out_fire),
    .not_empty (out_valid),
    .head      (head)
  );

  assign sector      = head.res.sector;
  assign enable_mask = head.res.enable_mask;
  assign pwm_phase   = head.res.pwm_phase;
  assign pwm_duty    = head.res.pwm_duty;
  assign sector_one  = head.res.sector_one;
  assign run_mode    = head.res.run_mode;
  assign avg_valid   = head.res.avg_valid;
  assign avg_period  = head.avg;

`ifndef SYNTHESIS
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credit <= (PTR_W + 1)'(OFIFO_DEPTH))
    else $error("in-flight count above queue depth");

  a_out_has_credit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> credit != '0)
    else $error("result shown with no request in flight");

  a_avg_masked: assert property (@(posedge clk) disable iff (rst)
    out_valid && !avg_valid |-> avg_period == 32'd0)
    else $error("average period nonzero outside a query");

  a_still_gated: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_mode == MODE_STILL |-> enable_mask == 3'd0)
    else $error("bridge enabled while still");
`endif

endmodule

FILE: tb/hall_six_step_commutator_unit_test.sv
// Self-checking testbench for the Hall-sensor six-step commutator unit.
`timescale 1ns / 100ps

module hall_six_step_commutator_unit_test;
  import hssc_pkg::*;

  localparam logic [2:0]           CMD_NONE   = 3'd7;
  localparam logic [1:0]           PIN_NONE   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  // PWM leg and bridge enables per sector, indexed by sector code
  localparam logic [0:7][1:0] PWM_LEG     = {2'd0, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd1, 2'd0};
  localparam logic [0:7][2:0] LEG_ENABLES = {3'd0, 3'd5, 3'd6, 3'd3, 3'd5, 3'd6, 3'd3, 3'd0};

  // Forward rotation: H3 rise, H2 fall, H1 rise, H3 fall, H2 rise, H1 fall
  localparam logic [0:5][1:0] EDGE_PIN   = {PIN_H3, PIN_H2, PIN_H1, PIN_H3, PIN_H2, PIN_H1};
  localparam logic [0:5]      EDGE_LEVEL = 6'b101010;

  typedef struct packed {
    logic [2:0]        sector;
    logic [2:0]        enable_mask;
    logic [1:0]        pwm_phase;
    logic [DUTY_W-1:0] pwm_duty;
    logic              sector_one;
    logic [1:0]        run_mode;
    logic [31:0]       avg_period;
    logic              avg_valid;
  } commutation_t;

  typedef struct packed {
    logic [2:0]   cmd;
    logic [1:0]   pin;
    logic         lvl;
    logic [31:0]  stamp;
    logic         typed;
    commutation_t want;
  } stim_row_t;

  typedef struct packed {
    logic [19:0] forced_duty;
    logic [19:0] start_duty;
    logic [19:0] duty_step;
    logic [15:0] dwell;
    logic [7:0]  turns;
    logic [15:0] check;
  } settings_t;

  localparam commutation_t STILL_VIEW =
    '{SEC_NONE, 3'd0, 2'd0, 20'd0, 1'b0, MODE_STILL, 32'd0, 1'b0};
  localparam commutation_t QUERY_VIEW =
    '{SEC_NONE, 3'd0, 2'd0, 20'd0, 1'b0, MODE_STILL, 32'd0, 1'b1};
  localparam commutation_t FORCED_S1_VIEW =
    '{SEC_1, 3'd5, 2'd1, DUTY_FULL, 1'b1, MODE_FORCED, 32'd0, 1'b0};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [2:0]            command = CMD_HALL;
  logic [1:0]            hall_pin = PIN_H1;
  logic                  hall_level = 1'b0;
  logic [31:0]           timestamp = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [2:0]            sector;
  logic [2:0]            enable_mask;
  logic [1:0]            pwm_phase;
  logic [DUTY_W-1:0]     pwm_duty;
  logic                  sector_one;
  logic [1:0]            run_mode;
  logic [31:0]           avg_period;
  logic                  avg_valid;

  hall_six_step_commutator_unit dut (.*);

  always #4 clk = ~clk;

  // Commutator shadow state
  settings_t         active_cfg;
  logic [1:0]        run_state = MODE_STILL;
  logic [19:0]       duty_now = '0;
  logic [19:0]       duty_latched = '0;
  logic [2:0]        sector_now = SEC_NONE;
  logic [2:0]        enables_now = '0;
  int unsigned       dwell_cnt = 0;
  int unsigned       turn_cnt = 0;
  int unsigned       check_cnt = 0;
  logic              edge_flag = 1'b0;
  logic [31:0]       last_h3_stamp = '0;
  logic [31:0]       period_hist [HISTORY];
  int                hist_pos = 0;
  logic [63:0]       period_total = '0;

  commutation_t      due_states [$];
  stim_row_t         directed_rows [$];
  commutation_t      oldest;
  int                src_idle_pct = 0;
  int                sink_stall_pct = 0;
  int                mismatches = 0;
  int                requests_sent = 0;
  int                results_checked = 0;
  int                forced_starts = 0;
  int                hall_handovers = 0;
  int                gate_offs = 0;
  int                ring_writes = 0;
  int                speed_queries = 0;
  logic [31:0]       stamp_clock = '0;
  int                rot_step = 0;

  function automatic logic [19:0] clamp_duty(input logic [31:0] v);
    return (v > 32'(DUTY_FULL)) ? DUTY_FULL : v[19:0];
  endfunction

  function automatic int unsigned floor_one(input int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  task latch_sector(input logic [2:0] s);
    sector_now   = s;
    enables_now  = LEG_ENABLES[s];
    duty_latched = duty_now;
  endtask

  task take_hall_edge(input logic [1:0] pin, input logic lvl, input logic [31:0] stamp);
    logic [31:0] diff;
    if (pin != PIN_NONE) begin
      edge_flag = 1'b1;
      if (pin == PIN_H3 && lvl) begin
        diff          = stamp - last_h3_stamp;
        last_h3_stamp = stamp;
        period_total  = period_total - 64'(period_hist[hist_pos]) + 64'(diff);
        period_hist[hist_pos] = diff;
        hist_pos      = (hist_pos + 1) % HISTORY;
        ring_writes++;
        latch_sector(SEC_1);
      end else if (pin == PIN_H2 && !lvl) begin
        latch_sector(SEC_2);
      end else if (pin == PIN_H1 && lvl) begin
        latch_sector(SEC_3);
      end else if (pin == PIN_H3) begin
        latch_sector(SEC_4);
      end else if (pin == PIN_H2) begin
        latch_sector(SEC_5);
      end else begin
        latch_sector(SEC_6);
      end
    end
  endtask

  task take_tick();
    if (run_state == MODE_FORCED) begin
      dwell_cnt++;
      if (dwell_cnt >= floor_one(active_cfg.dwell)) begin
        dwell_cnt = 0;
        if (sector_now >= SEC_6 || sector_now == SEC_NONE) begin
          turn_cnt++;
          if (turn_cnt >= floor_one(active_cfg.turns)) begin
            run_state = MODE_CHECK;
            duty_now  = clamp_duty(32'(active_cfg.start_duty));
            edge_flag = 1'b0;
            check_cnt = 0;
          end else begin
            latch_sector(SEC_1);
          end
        end else begin
          latch_sector(sector_now + 3'd1);
        end
      end
    end else if (run_state == MODE_CHECK) begin
      check_cnt++;
      if (check_cnt >= floor_one(active_cfg.check)) begin
        check_cnt = 0;
        if (edge_flag) begin
          run_state = MODE_RUN;
          hall_handovers++;
        end else begin
          enables_now = '0;
          run_state   = MODE_STILL;
          gate_offs++;
        end
      end
    end
  endtask

  task commutate(input logic [2:0] cmd, input logic [1:0] pin, input logic lvl,
                 input logic [31:0] stamp, output commutation_t res);
    logic [63:0] avg;
    logic        valid;
    avg   = '0;
    valid = 1'b0;
    case (cmd)
      CMD_HALL: begin
        if (run_state == MODE_CHECK || run_state == MODE_RUN) take_hall_edge(pin, lvl, stamp);
      end
      CMD_TICK: take_tick();
      CMD_START: begin
        if (run_state == MODE_STILL) begin
          run_state = MODE_FORCED;
          duty_now  = clamp_duty(32'(active_cfg.forced_duty));
          dwell_cnt = 0;
          turn_cnt  = 0;
          forced_starts++;
          latch_sector(SEC_1);
        end
      end
      CMD_STOP: begin
        if (run_state != MODE_STILL) begin
          enables_now = '0;
          run_state   = MODE_STILL;
        end
      end
      CMD_RAISE: duty_now = clamp_duty(32'(duty_now) + 32'(active_cfg.duty_step));
      CMD_LOWER: begin
        duty_now = (duty_now > active_cfg.duty_step) ?
                   clamp_duty(32'(duty_now - active_cfg.duty_step)) : '0;
      end
      CMD_QUERY: begin
        avg   = period_total / 64'(HISTORY);
        valid = 1'b1;
        speed_queries++;
      end
      default: ;
    endcase
    res.sector      = sector_now;
    res.enable_mask = enables_now;
    res.pwm_phase   = PWM_LEG[sector_now];
    res.pwm_duty    = duty_latched;
    res.sector_one  = (sector_now == SEC_1);
    res.run_mode    = run_state;
    res.avg_period  = avg[31:0];
    res.avg_valid   = valid;
  endtask

  task write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_FORCED_DUTY:  active_cfg.forced_duty = data;
      CFG_START_DUTY:   active_cfg.start_duty  = data;
      CFG_DUTY_STEP:    active_cfg.duty_step   = data;
      CFG_DWELL_TICKS:  active_cfg.dwell       = data[15:0];
      CFG_FORCED_TURNS: active_cfg.turns       = data[7:0];
      CFG_CHECK_TICKS:  active_cfg.check       = data[15:0];
      default: ;
    endcase
  endtask

  // Leaves cfg_valid high; the caller drops it after its last write
  task load_settings(input settings_t s);
    write_register(CFG_FORCED_DUTY, s.forced_duty);
    write_register(CFG_START_DUTY, s.start_duty);
    write_register(CFG_DUTY_STEP, s.duty_step);
    write_register(CFG_DWELL_TICKS, 20'(s.dwell));
    write_register(CFG_FORCED_TURNS, 20'(s.turns));
    write_register(CFG_CHECK_TICKS, 20'(s.check));
  endtask

  function automatic settings_t phase_settings(input int p);
    settings_t s;
    case (p)
      0:       s = '{20'd300000, 20'd700000, 20'd20000, 16'd2, 8'd2, 16'd20};
      1:       s = '{20'd1000000, 20'd1000000, 20'd0, 16'd1, 8'd1, 16'd65535};
      2:       s = '{20'd0, 20'hFFFFF, 20'hFFFFF, 16'd3, 8'd1, 16'd1};
      3:       s = '{20'd500000, 20'd250000, 20'd50000, 16'd1, 8'd3, 16'd10};
      default: s = '{20'hFFFFF, 20'd0, 20'd1000000, 16'd65535, 8'd255, 16'd65535};
    endcase
    return s;
  endfunction

  task automatic push_request(input logic [2:0] cmd, input logic [1:0] pin, input logic lvl,
                              input logic [31:0] stamp, input logic typed,
                              input commutation_t want);
    commutation_t predicted;
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    hall_pin   <= pin;
    hall_level <= lvl;
    timestamp  <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    commutate(cmd, pin, lvl, stamp, predicted);
    due_states.push_back(typed ? want : predicted);
    requests_sent++;
  endtask

  // Mostly well-formed start-up and rotation sequences, steered by the shadow mode
  task automatic pick_request(output logic [2:0] cmd, output logic [1:0] pin,
                              output logic lvl, output logic [31:0] stamp);
    int r;
    int q;
    r     = $urandom_range(99);
    cmd   = 3'($urandom_range(7));
    pin   = 2'($urandom_range(3));
    lvl   = 1'($urandom_range(1));
    stamp = $urandom;
    case (run_state)
      MODE_STILL: begin
        if (r < 60) cmd = CMD_START;
      end
      MODE_FORCED: begin
        if (r < 88) cmd = CMD_TICK;
        else if (r < 91) cmd = CMD_RAISE;
        else if (r < 94) cmd = CMD_LOWER;
        else if (r < 96) cmd = CMD_QUERY;
        else if (r < 97) cmd = CMD_STOP;
      end
      default: begin
        if (r < 70) begin
          cmd = CMD_HALL;
          stamp_clock += ($urandom_range(99) < 96) ? $urandom_range(1, 20000) : $urandom;
          stamp = stamp_clock;
          q = $urandom_range(99);
          if (q < 60) begin
            pin      = PIN_H3;
            lvl      = 1'b1;
            rot_step = 1;
          end else if (q < 92) begin
            pin      = EDGE_PIN[rot_step];
            lvl      = EDGE_LEVEL[rot_step];
            rot_step = (rot_step + 1) % 6;
          end
        end else if (r < 85) cmd = CMD_TICK;
        else if (r < 89) cmd = CMD_QUERY;
        else if (r < 93) cmd = CMD_RAISE;
        else if (r < 97) cmd = CMD_LOWER;
        else if (r < 98) cmd = CMD_STOP;
      end
    endcase
  endtask

  task automatic wait_drained();
    int spins;
    spins = 0;
    in_valid <= 1'b0;
    while (due_states.size() != 0 && spins < 5000) begin
      @(posedge clk);
      spins++;
    end
    repeat (12) @(posedge clk);
  endtask

  function automatic void field_match(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    out_stall <= (sink_stall_pct != 0) && ($urandom_range(99) < sink_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_checked++;
      if (due_states.size() == 0) begin
        $error("result arrived with no request pending (sector %0d, mode %0d)",
               sector, run_mode);
        mismatches++;
      end else begin
        oldest = due_states.pop_front();
        field_match("sector", 32'(oldest.sector), 32'(sector));
        field_match("enable_mask", 32'(oldest.enable_mask), 32'(enable_mask));
        field_match("pwm_phase", 32'(oldest.pwm_phase), 32'(pwm_phase));
        field_match("pwm_duty", 32'(oldest.pwm_duty), 32'(pwm_duty));
        field_match("sector_one", 32'(oldest.sector_one), 32'(sector_one));
        field_match("run_mode", 32'(oldest.run_mode), 32'(run_mode));
        field_match("avg_period", oldest.avg_period, avg_period);
        field_match("avg_valid", 32'(oldest.avg_valid), 32'(avg_valid));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [2:0]  cmd;
    logic [1:0]  pin;
    logic        lvl;
    logic [31:0] stamp;
    int          n_items;
    active_cfg = '{20'd400000, 20'd400000, 20'd20000, 16'd100, 8'd56, 16'd50000};
    foreach (period_hist[k]) period_hist[k] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Saturating forced duty, zero start duty, full step, one-tick dwell, one turn
    load_settings('{20'hFFFFF, 20'd0, 20'd1000000, 16'd7, 8'd0, 16'd2});
    write_register(CFG_DWELL_TICKS, 20'hF0000);  // upper bits drop, dwell reads as zero
    write_register(CFG_UNUSED, 20'h5A5A5);
    cfg_valid <= 1'b0;

    // Rows with typed clear take their expectation from the shadow model
    directed_rows.push_back('{CMD_QUERY, PIN_H1, 1'b0, 32'd0, 1'b1, QUERY_VIEW});
    directed_rows.push_back('{CMD_HALL, PIN_H3, 1'b1, 32'hFFFFFFFF, 1'b1, STILL_VIEW});
    directed_rows.push_back('{CMD_TICK, PIN_H1, 1'b0, 32'd0, 1'b1, STILL_VIEW});
    directed_rows.push_back('{CMD_STOP, PIN_H1, 1'b0, 32'd0, 1'b1, STILL_VIEW});
    directed_rows.push_back('{CMD_NONE, PIN_NONE, 1'b1, 32'h5555AAAA, 1'b1, STILL_VIEW});
    directed_rows.push_back('{CMD_LOWER, PIN_H1, 1'b0, 32'd0, 1'b1, STILL_VIEW});
    directed_rows.push_back('{CMD_RAISE, PIN_H1, 1'b0, 32'd0, 1'b1, STILL_VIEW});
    directed_rows.push_back('{CMD_RAISE, PIN_H1, 1'b0, 32'd0, 1'b1, STILL_VIEW});
    directed_rows.push_back('{CMD_START, PIN_H1, 1'b0, 32'd0, 1'b1, FORCED_S1_VIEW});
    repeat (6) directed_rows.push_back('{CMD_TICK, PIN_H1, 1'b0, 32'd0, 1'b0, STILL_VIEW});
    directed_rows.push_back('{CMD_HALL, PIN_H3, 1'b1, 32'hFFFFFFF0, 1'b0, STILL_VIEW});
    directed_rows.push_back('{CMD_HALL, PIN_H2, 1'b0, 32'd0, 1'b0, STILL_VIEW});
    directed_rows.push_back('{CMD_HALL, PIN_H1, 1'b1, 32'd0, 1'b0, STILL_VIEW});
    directed_rows.push_back('{CMD_HALL, PIN_H3, 1'b0, 32'd0, 1'b0, STILL_VIEW});
    directed_rows.push_back('{CMD_HALL, PIN_H2, 1'b1, 32'd0, 1'b0, STILL_VIEW});
    directed_rows.push_back('{CMD_HALL, PIN_H1, 1'b0, 32'd0, 1'b0, STILL_VIEW});
    directed_rows.push_back('{CMD_HALL, PIN_NONE, 1'b1, 32'hFFFFFFFF, 1'b0, STILL_VIEW});
    repeat (2) directed_rows.push_back('{CMD_TICK, PIN_H1, 1'b0, 32'd0, 1'b0, STILL_VIEW});
    // Timestamp wraps between the two H3 rises
    directed_rows.push_back('{CMD_HALL, PIN_H3, 1'b1, 32'h00000010, 1'b0, STILL_VIEW});
    directed_rows.push_back('{CMD_QUERY, PIN_H1, 1'b0, 32'd0, 1'b0, STILL_VIEW});
    directed_rows.push_back('{CMD_STOP, PIN_H1, 1'b0, 32'd0, 1'b0, STILL_VIEW});

    foreach (directed_rows[k]) begin
      push_request(directed_rows[k].cmd, directed_rows[k].pin, directed_rows[k].lvl,
                   directed_rows[k].stamp, directed_rows[k].typed, directed_rows[k].want);
    end
    wait_drained();

    stamp_clock = 32'h00000010;
    for (int p = 0; p < 5; p++) begin
      case (p)
        1:       begin src_idle_pct = 49; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 49; end
        3:       begin src_idle_pct = 14; sink_stall_pct = 14; end
        default: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      endcase
      load_settings(phase_settings(p));
      cfg_valid <= 1'b0;
      n_items = (p == 4) ? 120 : 380;
      repeat (n_items) begin
        pick_request(cmd, pin, lvl, stamp);
        push_request(cmd, pin, lvl, stamp, 1'b0, STILL_VIEW);
      end
      wait_drained();
    end

    if (due_states.size() != 0) begin
      $error("%0d results never arrived", due_states.size());
      mismatches++;
    end
    $display("Ran %0d requests over five settings and idle patterns; %0d results checked, %0d speed queries.",
             requests_sent, results_checked, speed_queries);
    $display("Forced starts %0d, Hall handovers %0d, gate-offs %0d, period ring writes %0d (depth %0d).",
             forced_starts, hall_handovers, gate_offs, ring_writes, HISTORY);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/hssc_pkg.sv
src/hssc_ram.sv
src/hssc_core.sv
src/hssc_avg.sv
src/hssc_ofifo.sv
src/hall_six_step_commutator_unit.sv
tb/hall_six_step_commutator_unit_test.sv
